FILE: rtl/core/zobrist_position_hash_assert.svh
// ---------------------------------------------------------------------------
// Zobrist position hash assertion macros
// Shorthand for clocked properties with reset disable, reporting by $error.
// ---------------------------------------------------------------------------
`ifndef ZOBRIST_POSITION_HASH_ASSERT_SVH
`define ZOBRIST_POSITION_HASH_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define ZPH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zph: next-cycle property failed");

// consequent checked in the same cycle as the antecedent
`define ZPH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zph: same-cycle property failed");

`endif

FILE: rtl/core/zph_pkg.sv
// ---------------------------------------------------------------------------
// Zobrist position hash package
// Shared constants, item types, state encoding and the key generator step.
// ---------------------------------------------------------------------------
`default_nettype none

package zph_pkg;

    localparam int SQUARES_DEF     = 64;
    localparam int PIECE_KINDS_DEF = 6;
    localparam int FILES_DEF       = 8;
    localparam int CASTLE_BITS_DEF = 4;
    localparam int COLORS          = 2;
    localparam int KEY_W           = 64;

    localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam logic [31:0] MULT_LO     = MIX_MULT[31:0];
    localparam logic [31:0] MULT_HI     = MIX_MULT[63:32];

    localparam int XS_A = 12;
    localparam int XS_B = 25;
    localparam int XS_C = 27;

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_SQUARE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [5:0] square;
        logic       occupied;
        logic       piece_owner;
        logic [2:0] piece_kind;
        logic       last;
        logic       black_to_move;
        logic [3:0] castle_rights;
        logic       ep_valid;
        logic [2:0] ep_file;
    } sq_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] hash;
    } hash_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_TAIL,
        S_EMIT
    } ctrl_state_t;

    function automatic logic [63:0] xorshift64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = x ^ (x >> XS_A);
        b = a ^ (a << XS_B);
        c = b ^ (b >> XS_C);
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/zph_stream_if.sv
// ---------------------------------------------------------------------------
// Zobrist position hash stream interface
// Valid/ready channel carrying one item of the given payload type.
// ---------------------------------------------------------------------------
`default_nettype none

interface zph_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input ready, input payload);
endinterface

`default_nettype wire

FILE: rtl/core/zobrist_position_hash.sv
// ---------------------------------------------------------------------------
// Zobrist position hash
// Chess position hasher with an xorshift64* key table held in one RAM.
//
// Channels: sq_item takes reseed and square items, hash_item returns one
// 64-bit hash per position. cfg_we/cfg_wdata load the seed register.
// A reseed item fills the TABLE_WORDS-entry key table, one key a cycle
// through a four-stage multiply; sq_item is held off until the last key
// is written.
// A square item that is not last leaves sq_item ready: its key read and
// accumulate overlap the next item.
// A last item reads the side key, min(CASTLE_BITS,4) castle keys and the
// en-passant key one a cycle from the table read port; the hash appears in
// the output register in the same cycle that sq_item is ready again.
// Reset clears the seed, generator and accumulator; the key table holds
// nothing valid until the first reseed, so hash only after one.
// A stalled hash_item holds its item; a later last item waits for the
// output register to drain, while square items keep flowing.
// ---------------------------------------------------------------------------
`default_nettype none

module zobrist_position_hash
    import zph_pkg::*;
#(
    parameter int SQUARES     = SQUARES_DEF,
    parameter int PIECE_KINDS = PIECE_KINDS_DEF,
    parameter int FILES       = FILES_DEF,
    parameter int CASTLE_BITS = CASTLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    zph_stream_if.sink       sq_item,
    zph_stream_if.source     hash_item
);

    localparam int TABLE_WORDS = PIECE_KINDS * COLORS * SQUARES + 1 + CASTLE_BITS + FILES;
    localparam int ADDR_W      = $clog2(TABLE_WORDS);

    logic              fill_start;
    logic              fill_done;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;

    zph_keygen #(
        .TABLE_WORDS (TABLE_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_keygen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fill_start (fill_start),
        .fill_done  (fill_done),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    zph_key_mem #(
        .DEPTH  (TABLE_WORDS),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    zph_ctrl #(
        .SQUARES     (SQUARES),
        .PIECE_KINDS (PIECE_KINDS),
        .FILES       (FILES),
        .CASTLE_BITS (CASTLE_BITS),
        .TABLE_WORDS (TABLE_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .sq_item    (sq_item),
        .hash_item  (hash_item),
        .fill_start (fill_start),
        .fill_done  (fill_done),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/zph_key_mem.sv
// ---------------------------------------------------------------------------
// Zobrist key table memory
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module zph_key_mem
    import zph_pkg::*;
#(
    parameter int DEPTH  = 781,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [KEY_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [KEY_W-1:0]  rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/zph_keygen.sv
// ---------------------------------------------------------------------------
// Zobrist key generator
// Holds the seed register, steps xorshift64* once a cycle while filling and
// writes each key via a four-stage split 64-bit multiply into the key table.
// ---------------------------------------------------------------------------
`default_nettype none

module zph_keygen
    import zph_pkg::*;
#(
    parameter int TABLE_WORDS = 781,
    parameter int ADDR_W      = $clog2(TABLE_WORDS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [63:0]       cfg_wdata,
    input  wire logic              fill_start,
    output logic                   fill_done,
    output logic                   wr_en,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [KEY_W-1:0]  wr_data
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_WORDS - 1);

    logic [63:0]       seed_reg;
    logic [63:0]       gen_reg;
    logic              running_reg;
    logic [ADDR_W-1:0] issue_cnt_reg;
    logic [ADDR_W-1:0] wr_cnt_reg;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [63:0] x1_reg;
    logic [63:0] p0_2_reg, p0_3_reg, p0_4_reg;
    logic [31:0] xh2_reg, xl2_reg, xl3_reg;
    logic [31:0] p1_3_reg, p1_4_reg, p2_4_reg;

    logic [63:0] gen_step;

    assign gen_step = xorshift64(gen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            gen_reg       <= '0;
            running_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            wr_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            v1_reg <= 1'b0;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (fill_start)
            begin
                gen_reg       <= (seed_reg == '0) ? GOLDEN_SEED : seed_reg;
                running_reg   <= 1'b1;
                issue_cnt_reg <= '0;
                wr_cnt_reg    <= '0;
            end
            else if (running_reg)
            begin
                gen_reg       <= gen_step;
                v1_reg        <= 1'b1;
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                if (issue_cnt_reg == LAST_ADDR)
                begin
                    running_reg <= 1'b0;
                end
            end
            if (v4_reg)
            begin
                wr_cnt_reg <= wr_cnt_reg + 1'b1;
            end
        end
    end

    // split multiply: low 64 bits of x * MIX_MULT
    always_ff @(posedge clk)
    begin
        x1_reg   <= gen_step;
        p0_2_reg <= {32'b0, x1_reg[31:0]} * {32'b0, MULT_LO};
        xh2_reg  <= x1_reg[63:32];
        xl2_reg  <= x1_reg[31:0];
        p1_3_reg <= xh2_reg * MULT_LO;
        p0_3_reg <= p0_2_reg;
        xl3_reg  <= xl2_reg;
        p2_4_reg <= xl3_reg * MULT_HI;
        p1_4_reg <= p1_3_reg;
        p0_4_reg <= p0_3_reg;
    end

    assign wr_en     = v4_reg;
    assign wr_addr   = wr_cnt_reg;
    assign wr_data   = {p0_4_reg[63:32] + p1_4_reg + p2_4_reg, p0_4_reg[31:0]};
    assign fill_done = v4_reg && (wr_cnt_reg == LAST_ADDR);

endmodule

`default_nettype wire

FILE: rtl/core/zph_ctrl.sv
// ---------------------------------------------------------------------------
// Zobrist hash controller
// Takes items, reads keys from the table, folds them into the accumulator
// and presents the finished hash in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module zph_ctrl
    import zph_pkg::*;
#(
    parameter int SQUARES     = SQUARES_DEF,
    parameter int PIECE_KINDS = PIECE_KINDS_DEF,
    parameter int FILES       = FILES_DEF,
    parameter int CASTLE_BITS = CASTLE_BITS_DEF,
    parameter int TABLE_WORDS = 781,
    parameter int ADDR_W      = $clog2(TABLE_WORDS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    zph_stream_if.sink             sq_item,
    zph_stream_if.source           hash_item,
    output logic                   fill_start,
    input  wire logic              fill_done,
    output logic                   rd_en,
    output logic      [ADDR_W-1:0] rd_addr,
    input  wire logic [KEY_W-1:0]  rd_data
);

    localparam int CASTLE_USED = (CASTLE_BITS < 4) ? CASTLE_BITS : 4;
    localparam int SIDE_BASE   = PIECE_KINDS * COLORS * SQUARES;
    localparam int EP_BASE     = SIDE_BASE + 1 + CASTLE_BITS;
    localparam int STEP_W      = $clog2(CASTLE_USED + 2);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CASTLE_USED + 1);
    localparam logic [STEP_W-1:0] EP_STEP   = STEP_W'(CASTLE_USED + 1);

    ctrl_state_t state_reg, state_next;
    logic [KEY_W-1:0]    acc_reg, acc_next, acc_sum;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                xor_en_reg, xor_en_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_hash_reg, out_hash_next;
    logic [CASTLE_USED:0] side_rights_reg, side_rights_shift;
    logic                ep_hit_reg;
    logic [2:0]          ep_file_reg;
    logic                tail_load;

    logic [3:0]          piece_idx;
    logic                sq_hit;
    logic                ep_hit;
    logic [ADDR_W-1:0]   sq_addr;
    logic [ADDR_W-1:0]   tail_addr;
    logic                tail_flag;
    logic                slot_free;

    assign piece_idx = {sq_item.payload.piece_kind, sq_item.payload.piece_owner};
    assign sq_hit    = sq_item.payload.occupied
                    && (32'(sq_item.payload.piece_kind) < PIECE_KINDS)
                    && (32'(sq_item.payload.square) < SQUARES);
    assign sq_addr   = ADDR_W'(piece_idx) * ADDR_W'(SQUARES)
                     + ADDR_W'(sq_item.payload.square);
    assign ep_hit    = sq_item.payload.ep_valid && (32'(sq_item.payload.ep_file) < FILES);

    assign side_rights_shift = side_rights_reg >> step_reg;
    assign tail_flag = (step_reg == EP_STEP) ? ep_hit_reg : side_rights_shift[0];
    assign tail_addr = (step_reg == EP_STEP)
                     ? ADDR_W'(EP_BASE) + ADDR_W'(ep_file_reg)
                     : ADDR_W'(SIDE_BASE) + ADDR_W'(step_reg);

    assign acc_sum   = acc_reg ^ (xor_en_reg ? rd_data : '0);
    assign slot_free = !out_valid_reg || hash_item.ready;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_sum;
        step_next      = step_reg;
        xor_en_next    = 1'b0;
        out_valid_next = out_valid_reg && !hash_item.ready;
        out_hash_next  = out_hash_reg;
        rd_en          = 1'b0;
        rd_addr        = sq_addr;
        fill_start     = 1'b0;
        tail_load      = 1'b0;
        sq_item.ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sq_item.ready = 1'b1;
                if (sq_item.valid)
                begin
                    if (sq_item.payload.cmd == CMD_RESEED)
                    begin
                        fill_start = 1'b1;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        xor_en_next = sq_hit;
                        if (sq_item.payload.last)
                        begin
                            tail_load  = 1'b1;
                            step_next  = '0;
                            state_next = S_TAIL;
                        end
                    end
                end
            end
            S_FILL:
            begin
                if (fill_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TAIL:
            begin
                rd_en       = 1'b1;
                rd_addr     = tail_addr;
                xor_en_next = tail_flag;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = acc_sum;
                    acc_next       = '0;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            step_reg      <= '0;
            xor_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            xor_en_reg    <= xor_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hash_reg <= out_hash_next;
        if (tail_load)
        begin
            side_rights_reg <= {sq_item.payload.castle_rights[CASTLE_USED-1:0],
                                sq_item.payload.black_to_move};
            ep_hit_reg      <= ep_hit;
            ep_file_reg     <= sq_item.payload.ep_file;
        end
    end

    assign hash_item.valid        = out_valid_reg;
    assign hash_item.payload.hash = out_hash_reg;

endmodule

`default_nettype wire

FILE: rtl/core/zph_checker.sv
// ---------------------------------------------------------------------------
// Zobrist position hash checker
// Port-level properties of the hasher, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "zobrist_position_hash_assert.svh"

module zph_checker
    import zph_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sq_valid,
    input  wire logic       sq_ready,
    input  wire sq_item_t   sq_payload,
    input  wire logic       hash_valid,
    input  wire logic       hash_ready,
    input  wire hash_item_t hash_payload
);

    logic sq_take;
    logic reseed_take;
    logic last_take;
    logic square_take;
    logic hash_stall;

    assign sq_take     = sq_valid && sq_ready;
    assign reseed_take = sq_take && (sq_payload.cmd == CMD_RESEED);
    assign last_take   = sq_take && (sq_payload.cmd == CMD_SQUARE) && sq_payload.last;
    assign square_take = sq_take && (sq_payload.cmd == CMD_SQUARE) && !sq_payload.last;
    assign hash_stall  = hash_valid && !hash_ready;

    `ZPH_ASSERT_NEXT(a_hash_hold, hash_stall, hash_valid && $stable(hash_payload))
    `ZPH_ASSERT_NEXT(a_reseed_busy, reseed_take, !sq_ready)
    `ZPH_ASSERT_NEXT(a_last_busy, last_take, !sq_ready)
    `ZPH_ASSERT_NEXT(a_square_stream, square_take, sq_ready)

endmodule

bind zobrist_position_hash zph_checker u_zph_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sq_valid     (sq_item.valid),
    .sq_ready     (sq_item.ready),
    .sq_payload   (sq_item.payload),
    .hash_valid   (hash_item.valid),
    .hash_ready   (hash_item.ready),
    .hash_payload (hash_item.payload)
);

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Zobrist position hash testbench
// Streams reseed and square items into the hasher and checks every hash
// against an in-bench model of the key generator, the key table and the
// accumulator. A short table of directed items comes first. Random positions
// follow under several seeds and under changing backpressure on both sides.
// ----------------------------------------------------------------------------
module tb;
    import zph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIECE_WORDS    = PIECE_KINDS_DEF * COLORS * SQUARES_DEF;
    localparam int SIDE_KEY       = PIECE_WORDS;
    localparam int CASTLE_KEY     = SIDE_KEY + 1;
    localparam int EP_KEY         = CASTLE_KEY + CASTLE_BITS_DEF;
    localparam int TABLE_WORDS    = EP_KEY + FILES_DEF;
    localparam int FILL_SETTLE    = TABLE_WORDS + 20;
    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 165;
    localparam int DIR_ROWS       = 20;

    typedef struct packed {
        sq_item_t    item;
        bit          typed;
        logic [63:0] hash;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    zph_stream_if #(.payload_t(sq_item_t))   sq_if ();
    zph_stream_if #(.payload_t(hash_item_t)) hash_if ();

    zobrist_position_hash u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sq_item   (sq_if),
        .hash_item (hash_if)
    );

    logic [63:0] seed_reg;
    logic [63:0] gen_state;
    logic [63:0] acc;
    logic [63:0] key_table [TABLE_WORDS];
    logic [63:0] hash_q [$];
    logic [63:0] exp_hash;

    int          src_idle;
    int          sink_idle;
    int          hold_requests;
    int          mismatches;
    int          quiet_cycles;
    int          items_sent;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{'{CMD_RESEED, 6'd0,  1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd0,  1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b1, '0},
        '{'{CMD_SQUARE, 6'd10, 1'b1, 1'b0, 3'd6, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd63, 1'b1, 1'b1, 3'd7, 1'b1, 1'b0, 4'h0, 1'b0, 3'd7}, 1'b1, '0},
        '{'{CMD_SQUARE, 6'd63, 1'b0, 1'b1, 3'd5, 1'b1, 1'b0, 4'h0, 1'b0, 3'd7}, 1'b1, '0},
        '{'{CMD_SQUARE, 6'd0,  1'b1, 1'b0, 3'd0, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd63, 1'b1, 1'b1, 3'd5, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd63, 1'b1, 1'b1, 3'd5, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd27, 1'b1, 1'b0, 3'd3, 1'b1, 1'b1, 4'hf, 1'b1, 3'd7}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd0,  1'b1, 1'b1, 3'd0, 1'b1, 1'b0, 4'h1, 1'b1, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd1,  1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 4'h2, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd2,  1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 4'h4, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd3,  1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 4'h8, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd4,  1'b0, 1'b0, 3'd0, 1'b1, 1'b1, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd40, 1'b1, 1'b0, 3'd2, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_RESEED, 6'd63, 1'b1, 1'b1, 3'd7, 1'b1, 1'b1, 4'hf, 1'b1, 3'd7}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd7,  1'b1, 1'b1, 3'd4, 1'b1, 1'b1, 4'h5, 1'b1, 3'd3}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd62, 1'b1, 1'b0, 3'd1, 1'b0, 1'b0, 4'h0, 1'b0, 3'd0}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd56, 1'b1, 1'b1, 3'd2, 1'b1, 1'b0, 4'ha, 1'b0, 3'd5}, 1'b0, '0},
        '{'{CMD_SQUARE, 6'd31, 1'b1, 1'b0, 3'd5, 1'b1, 1'b1, 4'h0, 1'b1, 3'd4}, 1'b0, '0}
    };

    always #5 clk = ~clk;

    task automatic key_table_fill();
        logic [63:0] x;
        int          i;
        x = (seed_reg != 64'd0) ? seed_reg : GOLDEN_SEED;
        for (i = 0; i < TABLE_WORDS; i++)
        begin
            x = x ^ (x >> XS_A);
            x = x ^ (x << XS_B);
            x = x ^ (x >> XS_C);
            key_table[i] = x * MIX_MULT;
        end
        gen_state = x;
    endtask

    task automatic position_hash_step(input sq_item_t it, output bit emits,
                                      output logic [63:0] h);
        int i;
        emits = 1'b0;
        h = '0;
        if (it.cmd == CMD_RESEED)
        begin
            key_table_fill();
        end
        else
        begin
            if (it.occupied && it.piece_kind < PIECE_KINDS_DEF && it.square < SQUARES_DEF)
                acc = acc ^ key_table[(int'(it.piece_kind) * COLORS + int'(it.piece_owner))
                                      * SQUARES_DEF + int'(it.square)];
            if (it.last)
            begin
                h = acc;
                if (it.black_to_move)
                    h = h ^ key_table[SIDE_KEY];
                for (i = 0; i < CASTLE_BITS_DEF && i < 4; i++)
                    if (it.castle_rights[i])
                        h = h ^ key_table[CASTLE_KEY + i];
                if (it.ep_valid && it.ep_file < FILES_DEF)
                    h = h ^ key_table[EP_KEY + int'(it.ep_file)];
                acc = '0;
                emits = 1'b1;
            end
        end
    endtask

    task automatic send_item(input sq_item_t it, input bit typed, input logic [63:0] typed_hash);
        bit          emits;
        logic [63:0] h;
        while ($urandom_range(99) < src_idle)
        begin
            sq_if.valid <= 1'b0;
            @(posedge clk);
        end
        sq_if.valid   <= 1'b1;
        sq_if.payload <= it;
        @(posedge clk);
        while (!sq_if.ready)
            @(posedge clk);
        position_hash_step(it, emits, h);
        if (emits)
            hash_q.push_back(typed ? typed_hash : h);
        items_sent++;
    endtask

    task automatic drain_hashes(input int settle);
        sq_if.valid <= 1'b0;
        @(posedge clk);
        while (hash_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        drain_hashes(FILL_SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_reg = value;
    endtask

    function automatic sq_item_t rand_square(input bit last);
        sq_item_t it;
        it.cmd           = CMD_SQUARE;
        it.square        = 6'($urandom_range(63));
        it.occupied      = ($urandom_range(99) < 80);
        it.piece_owner   = 1'($urandom_range(1));
        it.piece_kind    = ($urandom_range(99) < 90) ? 3'($urandom_range(5))
                                                     : 3'($urandom_range(7));
        it.last          = last;
        it.black_to_move = 1'($urandom_range(1));
        it.castle_rights = 4'($urandom_range(15));
        it.ep_valid      = 1'($urandom_range(1));
        it.ep_file       = 3'($urandom_range(7));
        return it;
    endfunction

    function automatic sq_item_t reseed_item();
        sq_item_t it;
        it     = rand_square(1'($urandom_range(1)));
        it.cmd = CMD_RESEED;
        return it;
    endfunction

    initial
    begin : hash_sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        hash_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                hash_if.ready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = STALL_CYCLES;
                hash_if.ready <= 1'b0;
            end
            else
            begin
                hash_if.ready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hash_if.valid && hash_if.ready)
        begin
            if (hash_q.size() == 0)
            begin
                $display("%0t: hash with none expected: expected none, actual %h",
                         $time, hash_if.payload.hash);
                mismatches++;
            end
            else
            begin
                exp_hash = hash_q.pop_front();
                if (hash_if.payload.hash !== exp_hash)
                begin
                    $display("%0t: hash mismatch: expected %h, actual %h",
                             $time, exp_hash, hash_if.payload.hash);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sq_if.valid && sq_if.ready) || (hash_if.valid && hash_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int       r;
        int       p;
        int       n;
        int       len;
        int       k;
        int       hold_phase;
        int       drain_phase;
        sq_item_t it;
        logic [63:0] seed_val;

        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        sq_if.valid   = 1'b0;
        sq_if.payload = '0;
        seed_reg      = '0;
        gen_state     = '0;
        acc           = '0;
        src_idle      = 22;
        sink_idle     = 68;
        hold_requests = 0;
        items_sent    = 0;
        hold_phase    = -1;
        drain_phase   = -1;
        for (r = 0; r < TABLE_WORDS; r++)
            key_table[r] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_seed(64'd0);
        for (r = 0; r < DIR_ROWS; r++)
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].hash);

        for (p = 0; p < PHASES; p++)
        begin
            case (p / 2)
                0:       begin src_idle = 22; sink_idle = 68; end
                1:       begin src_idle = 68; sink_idle = 22; end
                default: begin src_idle = 0;  sink_idle = 0;  end
            endcase
            case (p)
                0:       seed_val = 64'hFFFF_FFFF_FFFF_FFFF;
                1:       seed_val = 64'd1;
                3:       seed_val = 64'h8000_0000_0000_0000;
                5:       seed_val = 64'd0;
                default: seed_val = {$urandom, $urandom};
            endcase
            write_seed(seed_val);
            send_item(reseed_item(), 1'b0, '0);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ((p == 1 || p == 4) && n >= PHASE_ITEMS / 4 && hold_phase != p)
                begin
                    hold_phase = p;
                    hold_requests++;
                end
                if (p == 3 && n >= PHASE_ITEMS / 2 && drain_phase != p)
                begin
                    drain_phase = p;
                    drain_hashes(0);
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(49) == 0)
                        it = reseed_item();
                    else
                        it = rand_square(1'b0);
                    send_item(it, 1'b0, '0);
                    n++;
                end
                send_item(rand_square(1'b1), 1'b0, '0);
                n++;
            end
        end

        drain_hashes(FILL_SETTLE);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/zph_pkg.sv
rtl/core/zph_stream_if.sv
rtl/core/zph_key_mem.sv
rtl/core/zph_keygen.sv
rtl/core/zph_ctrl.sv
rtl/core/zobrist_position_hash.sv
rtl/core/zph_checker.sv
tb/tb.sv
